### rtl/twom_pkg.sv
// Shared constants, widths and the quarter-wave trig table for the three-wheel omni mixer.
// Used by three_wheel_omni_mixer; depends on nothing else.
package twom_pkg;

   localparam int TRIG_FRAC_BITS = 15;

   localparam int DEG_W       = 9;
   localparam int SPEED_W     = 7;
   localparam int BODY_W      = 8;
   localparam int OUT_W       = 8;
   localparam int QUO_W       = 7;
   localparam int REM_W       = 7;
   localparam int WHEELS      = 3;
   localparam int QUARTER_DEG = 90;
   localparam int FULL_DEG    = 360;

   localparam int TRIG_W  = TRIG_FRAC_BITS + 1;
   localparam int SC_W    = TRIG_FRAC_BITS + 2;
   localparam int COEF_W  = 2 * TRIG_FRAC_BITS + 2;
   localparam int WHEEL_W = COEF_W + BODY_W;
   localparam int MAG_W   = WHEEL_W - 1;
   localparam int DEN_W   = MAG_W + 1;
   localparam int NUM_W   = MAG_W + SPEED_W + 2;

   localparam logic [SPEED_W-1:0] MAX_SPEED_RESET = SPEED_W'(50);
   localparam logic [OUT_W-1:0]   OUT_MAX         = OUT_W'(127);

   localparam longint Q30_ONE  = 64'sd1073741824;
   localparam longint Q30_HALF = 64'sd536870912;
   localparam longint SIN1_Q30 = 64'sd18739379;
   localparam longint COS1_Q30 = 64'sd1073578288;
   localparam longint K_Q30    = 64'sd929887263;

   typedef logic [TRIG_W-1:0] trig_val_type;
   typedef trig_val_type trig_table_type [0:QUARTER_DEG];

   // Round a Q30 value half up to the trig fraction width, capped at 1.0.
   function automatic logic [63:0] to_frac(input longint v30);
      logic [63:0] r;
      r = (64'(v30) + (64'd1 << (29 - TRIG_FRAC_BITS))) >> (30 - TRIG_FRAC_BITS);
      if (r > (64'd1 << TRIG_FRAC_BITS)) begin
         r = 64'd1 << TRIG_FRAC_BITS;
      end
      return r;
   endfunction

   // Sine of 0..90 degrees, built by rotating one degree at a time in Q30.
   function automatic trig_table_type build_trig_table();
      longint         s;
      longint         c;
      longint         ns;
      longint         nc;
      trig_table_type t;
      s    = 64'sd0;
      c    = Q30_ONE;
      t[0] = trig_val_type'(to_frac(s));
      for (int i = 0; i < QUARTER_DEG; i++) begin
         ns = s * COS1_Q30 + c * SIN1_Q30 + Q30_HALF;
         ns = ns >>> 30;
         nc = c * COS1_Q30 - s * SIN1_Q30;
         if (nc < 0) begin
            nc = 64'sd0;
         end else begin
            nc = (nc + Q30_HALF) >>> 30;
         end
         s        = ns;
         c        = nc;
         t[i + 1] = trig_val_type'(to_frac(s));
      end
      return t;
   endfunction

   localparam trig_table_type TRIG_TABLE = build_trig_table();
   localparam trig_val_type   K_FRAC     = trig_val_type'(to_frac(K_Q30));

endpackage

### rtl/three_wheel_omni_mixer.sv
// Three-wheel omni drive mixer: heading and body speed in, three wheel commands out.
// Depends on twom_pkg for widths, constants and the trig table.

// Every request gives one response of three wheel speeds, A = V*cos(h) and
// B, C = V*(-cos(h)/2 +/- 0.866*sin(h)), rounded half away from zero and held
// to -127..127. If a wheel, checked in order A, B, C, would exceed csr max_speed
// in the positive direction, all three are scaled by max_speed over that wheel.
// The datapath is a 14-stage pipeline that takes one request per clock unless
// stalled; its depth is set mostly by the seven one-bit-per-stage restoring division
// steps that form the scale ratio. A stalled response backs up only as far as
// the first empty stage, so bubbles are filled while rsp_stall is high.
// max_speed should only be written while no request is in flight.
module three_wheel_omni_mixer
   import twom_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [DEG_W-1:0]         req_heading_deg,
   input  logic signed [BODY_W-1:0] req_body_speed,
   input  logic                     csr_write_enable,
   input  logic [SPEED_W-1:0]       csr_write_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_wheel_a,
   output logic signed [OUT_W-1:0]  rsp_wheel_b,
   output logic signed [OUT_W-1:0]  rsp_wheel_c
);

   localparam int DIV_FIRST = 7;
   localparam int OUT_STG   = DIV_FIRST + QUO_W;

   typedef struct packed {
      logic [1:0]         quad;
      logic [REM_W-1:0]   rem;
      logic [BODY_W-1:0]  vb;
      logic [SPEED_W-1:0] mx;
   } s1_type;

   typedef struct packed {
      logic [SC_W-1:0]    sn;
      logic [SC_W-1:0]    cs;
      logic [BODY_W-1:0]  vb;
      logic [SPEED_W-1:0] mx;
   } s2_type;

   typedef struct packed {
      logic [WHEELS-1:0][COEF_W-1:0] coef;
      logic [BODY_W-1:0]             vb;
      logic [SPEED_W-1:0]            mx;
   } s3_type;

   typedef struct packed {
      logic [WHEELS-1:0][WHEEL_W-1:0] w;
      logic [SPEED_W-1:0]             mx;
   } s4_type;

   typedef struct packed {
      logic [WHEELS-1:0][MAG_W-1:0] mag;
      logic [WHEELS-1:0]            neg;
      logic [MAG_W-1:0]             den;
      logic [SPEED_W-1:0]           mul;
   } s5_type;

   typedef struct packed {
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
      logic             sat;
      logic             neg;
   } lane_type;

   typedef struct packed {
      lane_type [WHEELS-1:0] lane;
      logic [DEN_W-1:0]      den2;
   } div_type;

   // ---------------------------------------------------------------- control
   logic [SPEED_W-1:0]   max_speed_ff;
   logic [SPEED_W-1:0]   max_speed_in;
   logic [OUT_STG:1]     v_ff;
   logic [OUT_STG:1]     v_in;
   logic [OUT_STG:1]     v_prev;
   logic [OUT_STG+1:1]   go;

   always_comb begin
      max_speed_in = csr_write_enable ? csr_write_data : max_speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff <= MAX_SPEED_RESET;
      end else begin
         max_speed_ff <= max_speed_in;
      end
   end

   // A stage may load when it is empty or when the stage after it moves on.
   assign go[OUT_STG+1] = !rsp_stall;
   for (genvar k = 1; k <= OUT_STG; k++) begin : g_go
      assign go[k] = !v_ff[k] || go[k+1];
   end

   assign v_prev = {v_ff[OUT_STG-1:1], req_valid};

   always_comb begin
      for (int k = 1; k <= OUT_STG; k++) begin
         v_in[k] = go[k] ? v_prev[k] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !go[1];
   assign rsp_valid = v_ff[OUT_STG];

   // ---------------------------------------- stage 1: fold heading, quadrant
   s1_type           s1_ff;
   s1_type           s1_in;
   logic [DEG_W-1:0] deg_fold;

   always_comb begin
      if (req_heading_deg >= DEG_W'(FULL_DEG)) begin
         deg_fold = req_heading_deg - DEG_W'(FULL_DEG);
      end else begin
         deg_fold = req_heading_deg;
      end
      s1_in.vb = req_body_speed;
      s1_in.mx = max_speed_ff;
      if (deg_fold >= DEG_W'(3 * QUARTER_DEG)) begin
         s1_in.quad = 2'd3;
         s1_in.rem  = REM_W'(deg_fold - DEG_W'(3 * QUARTER_DEG));
      end else if (deg_fold >= DEG_W'(2 * QUARTER_DEG)) begin
         s1_in.quad = 2'd2;
         s1_in.rem  = REM_W'(deg_fold - DEG_W'(2 * QUARTER_DEG));
      end else if (deg_fold >= DEG_W'(QUARTER_DEG)) begin
         s1_in.quad = 2'd1;
         s1_in.rem  = REM_W'(deg_fold - DEG_W'(QUARTER_DEG));
      end else begin
         s1_in.quad = 2'd0;
         s1_in.rem  = REM_W'(deg_fold);
      end
   end

   always_ff @(posedge clock) begin
      if (go[1]) begin
         s1_ff <= s1_in;
      end
   end

   // ------------------------------------------- stage 2: sine and cosine
   s2_type          s2_ff;
   s2_type          s2_in;
   logic [SC_W-1:0] sr_pos;
   logic [SC_W-1:0] cr_pos;

   always_comb begin
      sr_pos   = {1'b0, TRIG_TABLE[s1_ff.rem]};
      cr_pos   = {1'b0, TRIG_TABLE[REM_W'(QUARTER_DEG) - s1_ff.rem]};
      s2_in.vb = s1_ff.vb;
      s2_in.mx = s1_ff.mx;
      case (s1_ff.quad)
         2'd0: begin
            s2_in.sn = sr_pos;
            s2_in.cs = cr_pos;
         end
         2'd1: begin
            s2_in.sn = cr_pos;
            s2_in.cs = SC_W'(0) - sr_pos;
         end
         2'd2: begin
            s2_in.sn = SC_W'(0) - sr_pos;
            s2_in.cs = SC_W'(0) - cr_pos;
         end
         default: begin
            s2_in.sn = SC_W'(0) - cr_pos;
            s2_in.cs = sr_pos;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (go[2]) begin
         s2_ff <= s2_in;
      end
   end

   // ------------------------------------- stage 3: unit wheel coefficients
   s3_type                     s3_ff;
   s3_type                     s3_in;
   logic signed [2*SC_W-1:0]   k_ext;
   logic signed [2*SC_W-1:0]   s_ext;
   logic signed [2*SC_W-1:0]   ks_full;
   logic signed [COEF_W-1:0]   ks;
   logic signed [COEF_W-1:0]   c_ext;
   logic signed [COEF_W-1:0]   c_half;

   always_comb begin
      k_ext   = $signed({{(SC_W + 1){1'b0}}, K_FRAC});
      s_ext   = $signed({{SC_W{s2_ff.sn[SC_W-1]}}, s2_ff.sn});
      ks_full = k_ext * s_ext;
      ks      = $signed(ks_full[COEF_W-1:0]);
      c_ext   = $signed({{(COEF_W - SC_W){s2_ff.cs[SC_W-1]}}, s2_ff.cs});
      c_half  = c_ext <<< (TRIG_FRAC_BITS - 1);
      s3_in.coef[0] = c_ext <<< TRIG_FRAC_BITS;
      s3_in.coef[1] = ks - c_half;
      s3_in.coef[2] = COEF_W'(0) - ks - c_half;
      s3_in.vb      = s2_ff.vb;
      s3_in.mx      = s2_ff.mx;
   end

   always_ff @(posedge clock) begin
      if (go[3]) begin
         s3_ff <= s3_in;
      end
   end

   // ------------------------------------------ stage 4: scale by body speed
   s4_type                    s4_ff;
   s4_type                    s4_in;
   logic signed [WHEEL_W-1:0] vb_x;
   logic signed [WHEEL_W-1:0] coef_x [WHEELS];
   logic signed [WHEEL_W-1:0] w_x [WHEELS];

   always_comb begin
      vb_x = $signed({{(WHEEL_W - BODY_W){s3_ff.vb[BODY_W-1]}}, s3_ff.vb});
      for (int j = 0; j < WHEELS; j++) begin
         coef_x[j] = $signed({{(WHEEL_W - COEF_W){s3_ff.coef[j][COEF_W-1]}},
                              s3_ff.coef[j]});
         w_x[j]     = coef_x[j] * vb_x;
         s4_in.w[j] = w_x[j];
      end
      s4_in.mx = s3_ff.mx;
   end

   always_ff @(posedge clock) begin
      if (go[4]) begin
         s4_ff <= s4_in;
      end
   end

   // ------------------------------ stage 5: pick the wheel that sets the scale
   s5_type             s5_ff;
   s5_type             s5_in;
   logic [MAG_W-1:0]   lim;
   logic [WHEEL_W-1:0] w_neg [WHEELS];
   logic [WHEELS-1:0]  over;
   logic               found;

   always_comb begin
      lim   = MAG_W'(s4_ff.mx) << (2 * TRIG_FRAC_BITS);
      found = 1'b0;
      s5_in.den = MAG_W'(1) << (2 * TRIG_FRAC_BITS);
      for (int j = 0; j < WHEELS; j++) begin
         w_neg[j]        = WHEEL_W'(0) - s4_ff.w[j];
         s5_in.neg[j]    = s4_ff.w[j][WHEEL_W-1];
         s5_in.mag[j]    = s4_ff.w[j][WHEEL_W-1] ? w_neg[j][MAG_W-1:0]
                                                 : s4_ff.w[j][MAG_W-1:0];
         over[j]         = !s4_ff.w[j][WHEEL_W-1] && (s4_ff.w[j][MAG_W-1:0] > lim);
      end
      // The first overshooting wheel in A, B, C order wins.
      for (int j = 0; j < WHEELS; j++) begin
         if (!found && over[j]) begin
            s5_in.den = s4_ff.w[j][MAG_W-1:0];
            found     = 1'b1;
         end
      end
      s5_in.mul = found ? s4_ff.mx : SPEED_W'(1);
   end

   always_ff @(posedge clock) begin
      if (go[5]) begin
         s5_ff <= s5_in;
      end
   end

   // ----------------------- stage 6: rounded-division numerator and divisor
   div_type          div_ff [0:QUO_W];
   div_type          div_in [0:QUO_W];
   logic [NUM_W-1:0] mag_x [WHEELS];
   logic [NUM_W-1:0] mul_x;
   logic [NUM_W-1:0] prod [WHEELS];

   // round(n / den) = floor((2n + den) / (2den)).
   always_comb begin
      mul_x          = NUM_W'(s5_ff.mul);
      div_in[0].den2 = {s5_ff.den, 1'b0};
      for (int j = 0; j < WHEELS; j++) begin
         mag_x[j]               = NUM_W'(s5_ff.mag[j]);
         prod[j]                = mag_x[j] * mul_x;
         div_in[0].lane[j].rem  = (prod[j] << 1) + NUM_W'(s5_ff.den);
         div_in[0].lane[j].quo  = '0;
         div_in[0].lane[j].sat  = 1'b0;
         div_in[0].lane[j].neg  = s5_ff.neg[j];
      end
   end

   always_ff @(posedge clock) begin
      if (go[6]) begin
         div_ff[0] <= div_in[0];
      end
   end

   // ------------------------------- stage 7: saturation, then 7 quotient bits
   logic [NUM_W-1:0] sat_lim;

   always_comb begin
      sat_lim        = NUM_W'(div_ff[0].den2) << QUO_W;
      div_in[1]      = div_ff[0];
      for (int j = 0; j < WHEELS; j++) begin
         div_in[1].lane[j].sat = div_ff[0].lane[j].rem >= sat_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (go[DIV_FIRST]) begin
         div_ff[1] <= div_in[1];
      end
   end

   for (genvar t = 2; t <= QUO_W; t++) begin : g_div
      localparam int BIT = QUO_W + 1 - t;
      logic [NUM_W-1:0] trial;

      always_comb begin
         trial     = NUM_W'(div_ff[t-1].den2) << BIT;
         div_in[t] = div_ff[t-1];
         for (int j = 0; j < WHEELS; j++) begin
            if (div_ff[t-1].lane[j].rem >= trial) begin
               div_in[t].lane[j].rem      = div_ff[t-1].lane[j].rem - trial;
               div_in[t].lane[j].quo[BIT] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (go[DIV_FIRST + t - 1]) begin
            div_ff[t] <= div_in[t];
         end
      end
   end

   // The last bit is taken together with the sign in the output stage.
   logic [NUM_W-1:0]               trial_last;
   logic [QUO_W-1:0]               quo_last [WHEELS];
   logic [OUT_W-1:0]               mag_out [WHEELS];
   logic [WHEELS-1:0][OUT_W-1:0]   wheel_ff;
   logic [WHEELS-1:0][OUT_W-1:0]   wheel_in;

   always_comb begin
      trial_last = NUM_W'(div_ff[QUO_W].den2);
      for (int j = 0; j < WHEELS; j++) begin
         quo_last[j]    = div_ff[QUO_W].lane[j].quo;
         quo_last[j][0] = div_ff[QUO_W].lane[j].rem >= trial_last;
         mag_out[j]     = div_ff[QUO_W].lane[j].sat ? OUT_MAX : {1'b0, quo_last[j]};
         wheel_in[j]    = div_ff[QUO_W].lane[j].neg ? OUT_W'(0) - mag_out[j] : mag_out[j];
      end
   end

   always_ff @(posedge clock) begin
      if (go[OUT_STG]) begin
         wheel_ff <= wheel_in;
      end
   end

   assign rsp_wheel_a = $signed(wheel_ff[0]);
   assign rsp_wheel_b = $signed(wheel_ff[1]);
   assign rsp_wheel_c = $signed(wheel_ff[2]);

   // ------------------------------------------------------------- assertions
   // Before the last division step the remainder of an unsaturated lane is
   // below twice the divisor, so one more compare finishes the quotient.
   a_div_remainder: assert property (@(posedge clock) disable iff (reset)
      v_ff[OUT_STG-1] |->
         (div_ff[QUO_W].lane[0].sat ||
          div_ff[QUO_W].lane[0].rem < (NUM_W'(div_ff[QUO_W].den2) << 1)) &&
         (div_ff[QUO_W].lane[1].sat ||
          div_ff[QUO_W].lane[1].rem < (NUM_W'(div_ff[QUO_W].den2) << 1)) &&
         (div_ff[QUO_W].lane[2].sat ||
          div_ff[QUO_W].lane[2].rem < (NUM_W'(div_ff[QUO_W].den2) << 1)))
      else $error("division remainder out of range");

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_wheel_a >= -8'sd127) && (rsp_wheel_b >= -8'sd127) &&
                    (rsp_wheel_c >= -8'sd127))
      else $error("wheel command outside -127..127");

   // Requests are held off only when every stage is full and the output is blocked.
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (&v_ff) && rsp_stall)
      else $error("request stalled with room in the pipeline");

endmodule
